/* rtl/dws_pkg.sv */
// shared types and constants for the double-ended queue with search
`default_nettype none

package dws_pkg;

  // fixed widths of the stream fields
  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned TOTAL_W  = 5;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_DUMP       = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // one result as handed from the sequencer to the output register
  typedef struct packed {
    status_e              status;
    logic [VALUE_W-1:0]   result_value;
    logic [TOTAL_W-1:0]   item_total;
    logic [VALUE_W-1:0]   front_value;
    logic [VALUE_W-1:0]   back_value;
    logic                 run_end;
  } res_t;

endpackage

`default_nettype wire

/* rtl/dws_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module dws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/dws_seq.sv */
// request sequencer: ring pointers, shared slot adder and compare, scan and shift walks
`default_nettype none

module dws_seq #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire dws_pkg::op_e             in_op_i,
  input  wire logic [DATA_WIDTH-1:0]    in_key_i,
  input  wire logic                     out_free_i,
  output logic                          res_valid_o,
  output dws_pkg::res_t                 res_o,
  output logic                          mem_we_o,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr_o,
  output logic [DATA_WIDTH-1:0]         mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr_o,
  input  wire logic [DATA_WIDTH-1:0]    mem_rdata_i
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REF_F,
    S_REF_B,
    S_REF_E,
    S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  dws_pkg::op_e           op_q, op_d;
  logic [DATA_WIDTH-1:0]  key_q, key_d;
  logic [IDX_W-1:0]       front_q, front_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       k_q, k_d;
  logic [DATA_WIDTH-1:0]  front_val_q, front_val_d;
  logic [DATA_WIDTH-1:0]  back_val_q, back_val_d;
  dws_pkg::status_e       st_q, st_d;
  logic [DATA_WIDTH-1:0]  rv_q, rv_d;

  // shared slot adder: ring position of the entry at offset off from the front
  logic [CNT_W-1:0]       off;
  logic [IDX_W:0]         sum;
  logic [IDX_W:0]         wrapped;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       new_front;
  logic [CNT_W-1:0]       k_inc;
  logic                   hit;

  dws_pkg::status_e       res_st;
  logic [DATA_WIDTH-1:0]  res_rv;
  logic                   res_last;

  assign sum     = {1'b0, front_q} + {1'b0, off[IDX_W-1:0]};
  assign wrapped = (sum >= DEPTH_X) ? (sum - DEPTH_X) : sum;
  assign slot    = wrapped[IDX_W-1:0];

  assign new_front = (front_q == '0) ? LAST_IDX : (front_q - IDX_W'(1));
  assign k_inc     = k_q + CNT_W'(1);
  assign hit       = (mem_rdata_i == key_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    front_d     = front_q;
    count_d     = count_q;
    k_d         = k_q;
    front_val_d = front_val_q;
    back_val_d  = back_val_q;
    st_d        = st_q;
    rv_d        = rv_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    off         = k_q;
    mem_waddr_o = slot;
    mem_raddr_o = slot;
    mem_wdata_o = key_q;
    res_valid_o = 1'b0;
    res_st      = st_q;
    res_rv      = rv_q;
    res_last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_op_i;
          key_d   = in_key_i;
          k_d     = '0;
          rv_d    = '0;
          st_d    = dws_pkg::ST_OK;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_EMIT;
        case (op_q)
          dws_pkg::OP_PUSH_FRONT: begin
            if (count_q == CNT_FULL) begin
              st_d = dws_pkg::ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = new_front;
              front_d     = new_front;
              count_d     = count_q + CNT_W'(1);
              front_val_d = key_q;
              if (count_q == '0) begin
                back_val_d = key_q;
              end
            end
          end
          dws_pkg::OP_PUSH_BACK: begin
            off = count_q;
            if (count_q == CNT_FULL) begin
              st_d = dws_pkg::ST_FULL;
            end else begin
              mem_we_o   = 1'b1;
              count_d    = count_q + CNT_W'(1);
              back_val_d = key_q;
              if (count_q == '0) begin
                front_val_d = key_q;
              end
            end
          end
          dws_pkg::OP_POP_FRONT: begin
            off = CNT_W'(1);
            if (count_q == '0) begin
              st_d = dws_pkg::ST_EMPTY;
            end else begin
              rv_d    = front_val_q;
              front_d = slot;
              count_d = count_q - CNT_W'(1);
              state_d = S_REF_F;
            end
          end
          dws_pkg::OP_POP_BACK: begin
            if (count_q == '0) begin
              st_d = dws_pkg::ST_EMPTY;
            end else begin
              rv_d    = back_val_q;
              count_d = count_q - CNT_W'(1);
              state_d = S_REF_F;
            end
          end
          dws_pkg::OP_FIND, dws_pkg::OP_REMOVE: begin
            state_d = S_SCAN_RD;
          end
          dws_pkg::OP_DUMP: begin
            if (count_q == '0) begin
              st_d = dws_pkg::ST_EMPTY;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
          default: begin
            state_d = S_EMIT;
          end
        endcase
      end

      S_SCAN_RD: begin
        if (k_q == count_q) begin
          st_d    = dws_pkg::ST_NOT_FOUND;
          state_d = S_EMIT;
        end else begin
          mem_re_o = 1'b1;
          state_d  = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (op_q == dws_pkg::OP_DUMP) begin
          // read data holds while the output register is busy
          if (out_free_i) begin
            res_valid_o = 1'b1;
            res_st      = dws_pkg::ST_OK;
            res_rv      = mem_rdata_i;
            res_last    = (k_inc == count_q);
            k_d         = k_inc;
            state_d     = (k_inc == count_q) ? S_IDLE : S_SCAN_RD;
          end
        end else if (hit) begin
          if (op_q == dws_pkg::OP_FIND) begin
            rv_d    = mem_rdata_i;
            state_d = S_EMIT;
          end else begin
            state_d = S_SHIFT_CHK;
          end
        end else begin
          k_d     = k_inc;
          state_d = S_SCAN_RD;
        end
      end

      S_SHIFT_CHK: begin
        if (k_inc < count_q) begin
          state_d = S_SHIFT_RD;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_REF_F;
        end
      end

      S_SHIFT_RD: begin
        off      = k_inc;
        mem_re_o = 1'b1;
        state_d  = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        // close the gap: entry k takes the one behind it
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        k_d         = k_inc;
        state_d     = S_SHIFT_CHK;
      end

      S_REF_F: begin
        off = '0;
        if (count_q == '0) begin
          state_d = S_EMIT;
        end else begin
          mem_re_o = 1'b1;
          state_d  = S_REF_B;
        end
      end

      S_REF_B: begin
        front_val_d = mem_rdata_i;
        off         = count_q - CNT_W'(1);
        mem_re_o    = 1'b1;
        state_d     = S_REF_E;
      end

      S_REF_E: begin
        back_val_d = mem_rdata_i;
        state_d    = S_EMIT;
      end

      S_EMIT: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.status       = res_st;
    res_o.result_value = dws_pkg::VALUE_W'(res_rv);
    res_o.item_total   = dws_pkg::TOTAL_W'(count_q);
    res_o.front_value  = (count_q != '0) ? dws_pkg::VALUE_W'(front_val_q) : '0;
    res_o.back_value   = (count_q != '0) ? dws_pkg::VALUE_W'(back_val_q) : '0;
    res_o.run_end      = res_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    k_q         <= k_d;
    front_val_q <= front_val_d;
    back_val_q  <= back_val_d;
    st_q        <= st_d;
    rv_q        <= rv_d;
  end

endmodule

`default_nettype wire

/* rtl/deque_with_search.sv */
// double-ended queue with key search: push and pop at either end, find and remove walk the
// entries from the front, a remove closes the gap by moving each later entry one place toward
// the front, and a dump streams every entry; one ram and the scan sequencer serve all of these.
// one request is in work at a time; a result waits in the output register while the next
// request is taken. reset clears pointers, count and valid flags, ring contents stay as
// they are and are never read before being written
`default_nettype none

module deque_with_search #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // value
  input  wire logic [2:0]   s_axis_tuser,   // op
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,   // result_value, item_total, front_value,
                                            // back_value, zero fill
  output logic [1:0]        m_axis_tuser,   // status
  output logic              m_axis_tlast    // run_end
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                   out_free;
  logic                   res_valid;
  dws_pkg::res_t          res;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [DATA_WIDTH-1:0]  mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [DATA_WIDTH-1:0]  mem_rdata;

  logic                   out_valid_q, out_valid_d;
  dws_pkg::res_t          out_res_q;

  dws_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (dws_pkg::op_e'(s_axis_tuser)),
    .in_key_i    (DATA_WIDTH'(s_axis_tdata)),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  dws_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register frees when empty or when its transfer completes
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tlast  = out_res_q.run_end;
  assign m_axis_tdata  = {3'b000, out_res_q.back_value, out_res_q.front_value,
                          out_res_q.item_total, out_res_q.result_value};

endmodule

`default_nettype wire
